/* rtl/avrx_pkg.sv */
// Shared types, constants and the instruction decoder for the 8-bit
// instruction executor. No dependencies; used by every file under rtl/.
package avrx_pkg;

  localparam int PC_BITS   = 12;
  localparam int REG_COUNT = 32;
  localparam int REG_BITS  = $clog2(REG_COUNT);
  localparam int ROWS      = REG_COUNT / 2;
  localparam int ROW_BITS  = REG_BITS - 1;

  localparam logic [5:0] PORT_ADDR = 6'h18;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD,
    OP_ADC,
    OP_SUB,
    OP_SUBI,
    OP_SBCI,
    OP_SBIW,
    OP_LDI,
    OP_CLC,
    OP_SEC,
    OP_OUT,
    OP_RJMP,
    OP_BRNE
  } op_t;

  // One write into the register file: a row holds an even/odd register pair.
  typedef struct packed {
    logic                en;
    logic [ROW_BITS-1:0] row;
    logic [1:0]          be;
    logic [15:0]         data;
  } wr_req_t;

  function automatic op_t decode(input logic [15:0] w);
    op_t op;
    op = OP_NOP;
    unique casez (w)
      16'b0000_11??_????_????: op = OP_ADD;
      16'b0001_11??_????_????: op = OP_ADC;
      16'b0001_10??_????_????: op = OP_SUB;
      16'b0101_????_????_????: op = OP_SUBI;
      16'b0100_????_????_????: op = OP_SBCI;
      16'b1001_0111_????_????: op = OP_SBIW;
      16'b1110_????_????_????: op = OP_LDI;
      16'b1001_0100_1000_1000: op = OP_CLC;
      16'b1001_0100_0000_1000: op = OP_SEC;
      16'b1011_1???_????_????: op = OP_OUT;
      16'b1100_????_????_????: op = OP_RJMP;
      16'b1111_01??_????_?001: op = OP_BRNE;
      default:                 op = OP_NOP;
    endcase
    return op;
  endfunction

endpackage

/* rtl/avrx_regfile.sv */
// Register file: a 16-row by 16-bit synchronous memory of register pairs,
// two registered read ports, one byte-enabled write port, per-register valid
// bits for the all-zero reset, and forwarding of a write that lands together
// with a read. Depends on avrx_pkg.
module avrx_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [avrx_pkg::ROW_BITS-1:0] raddr_a,
  input  logic [avrx_pkg::ROW_BITS-1:0] raddr_b,
  input  avrx_pkg::wr_req_t             wr,
  output logic [15:0]                   rdata_a,
  output logic [15:0]                   rdata_b
);

  logic [15:0]                   mem [avrx_pkg::ROWS];
  logic [15:0]                   q_a;
  logic [15:0]                   q_b;
  logic [avrx_pkg::ROW_BITS-1:0] row_a;
  logic [avrx_pkg::ROW_BITS-1:0] row_b;
  logic [avrx_pkg::REG_COUNT-1:0] vld;
  avrx_pkg::wr_req_t             fwd;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.be[0]) mem[wr.row][7:0]  <= wr.data[7:0];
      if (wr.be[1]) mem[wr.row][15:8] <= wr.data[15:8];
    end
    if (rd_en) begin
      q_a   <= mem[raddr_a];
      q_b   <= mem[raddr_b];
      row_a <= raddr_a;
      row_b <= raddr_b;
    end
  end

  // The write that shares a clock edge with a read is captured with it, so
  // the read data can be patched with the newer bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      fwd <= '0;
    end else begin
      if (wr.en) begin
        if (wr.be[0]) vld[{wr.row, 1'b0}] <= 1'b1;
        if (wr.be[1]) vld[{wr.row, 1'b1}] <= 1'b1;
      end
      if (rd_en) fwd <= wr;
    end
  end

  function automatic logic [15:0] merge(
    input logic [15:0]                   q,
    input logic [avrx_pkg::ROW_BITS-1:0] row,
    input avrx_pkg::wr_req_t             f,
    input logic [avrx_pkg::REG_COUNT-1:0] v
  );
    logic [15:0] d;
    d = '0;
    for (int j = 0; j < 2; j++) begin
      if (f.en && f.be[j] && (f.row == row)) begin
        d[j*8 +: 8] = f.data[j*8 +: 8];
      end else if (v[{row, 1'(j)}]) begin
        d[j*8 +: 8] = q[j*8 +: 8];
      end
    end
    return d;
  endfunction

  assign rdata_a = merge(q_a, row_a, fwd, vld);
  assign rdata_b = merge(q_b, row_b, fwd, vld);

endmodule

/* rtl/avr_subset_instruction_execute_top.sv */
// Top level of the 8-bit instruction executor: decode, register file reads,
// execute, write-back and the result register. Depends on avrx_pkg and
// avrx_regfile.
//
// Usage: one instruction word enters per item on the input channel
// (instruction, in_valid, in_ready). For each item exactly one result item
// leaves on the output channel (out_valid, out_ready) with the next PC, the
// status flags, the pin levels and the register write, if any.
// The edge that accepts an item also issues the register file reads; the item
// waits in the execute stage while the result register stalls, and the edge
// that executes it loads the result register. Throughput is one item per cycle
// while out_ready is high; the register file serves both operand reads of an
// item from its two read ports and takes one write (a byte, or a full pair for
// SBIW) per cycle. A write that lands on the edge of the next item's read is
// forwarded into that item's operands, so dependent items run back to back.
// Reset (rst, synchronous, active high) clears the flags, the PC, the pin
// levels and the register file valid bits, so every register reads as zero
// until written; both pipeline stages are emptied. When the receiver holds
// out_ready low, the result register keeps its item, the execute stage holds
// one more item, and in_ready drops until the result is taken.
module avr_subset_instruction_execute_top (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] instruction,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [11:0] next_pc,
  output logic [7:0]  status_flags,
  output logic [5:0]  pin_levels,
  output logic        reg_written,
  output logic [4:0]  written_index,
  output logic [7:0]  written_value,
  output logic        out_valid,
  input  logic        out_ready
);

  // Decode stage: pick the register pair rows to read.
  avrx_pkg::op_t                 op0;
  logic [avrx_pkg::ROW_BITS-1:0] raddr_a;
  logic [avrx_pkg::ROW_BITS-1:0] raddr_b;
  logic                          in_fire;

  // Execute stage.
  logic                          s1_valid;
  avrx_pkg::op_t                 s1_op;
  logic [15:0]                   s1_instr;
  logic                          s1_go;
  logic [15:0]                   rdata_a;
  logic [15:0]                   rdata_b;

  // Architectural state outside the register file.
  logic [7:0]                    flags;
  logic [7:0]                    flags_next;
  logic [avrx_pkg::PC_BITS-1:0]  pc;
  logic [avrx_pkg::PC_BITS-1:0]  pc_next;
  logic [5:0]                    port;
  logic [5:0]                    port_next;

  avrx_pkg::wr_req_t             wr;
  logic                          wrote;
  logic [avrx_pkg::REG_BITS-1:0] widx;
  logic [7:0]                    wval;

  assign op0     = avrx_pkg::decode(instruction);
  assign in_fire = in_valid && in_ready;
  assign s1_go   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  // Port A carries the destination (or the SBIW pair), port B the source.
  always_comb begin
    unique case (op0)
      avrx_pkg::OP_SUBI, avrx_pkg::OP_SBCI, avrx_pkg::OP_LDI: begin
        raddr_a = {1'b1, instruction[7:5]};
      end
      avrx_pkg::OP_SBIW: begin
        raddr_a = {2'b11, instruction[5:4]};
      end
      default: begin
        raddr_a = instruction[8:5];
      end
    endcase
  end
  assign raddr_b = {instruction[9], instruction[3:1]};

  avrx_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .wr      (wr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op    <= op0;
      s1_instr <= instruction;
    end
  end

  // Operand and immediate fields of the instruction in the execute stage.
  logic [avrx_pkg::REG_BITS-1:0] rd5;
  logic [avrx_pkg::REG_BITS-1:0] rdh;
  logic [7:0]                    kimm;
  logic [7:0]                    a;
  logic [7:0]                    b_reg;
  logic [7:0]                    b;
  logic                          is_sub;
  logic                          use_imm;
  logic                          cin;
  logic [8:0]                    sum9;
  logic [8:0]                    dif9;
  logic [8:0]                    res9;
  logic [7:0]                    r;
  logic                          hc;
  logic                          vf;
  logic                          zf;
  logic [15:0]                   k16;
  logic [15:0]                   res16;
  logic                          v16;
  logic [5:0]                    io_addr;
  logic [15:0]                   rj_off;
  logic [15:0]                   br_off;
  logic [avrx_pkg::PC_BITS-1:0]  pc_inc;

  assign rd5     = s1_instr[8:4];
  assign rdh     = {1'b1, s1_instr[7:4]};
  assign kimm    = {s1_instr[11:8], s1_instr[3:0]};
  // Bit 4 selects the byte of the pair for both the full and the upper-half
  // register forms.
  assign a       = s1_instr[4] ? rdata_a[15:8] : rdata_a[7:0];
  assign b_reg   = s1_instr[0] ? rdata_b[15:8] : rdata_b[7:0];
  assign use_imm = (s1_op == avrx_pkg::OP_SUBI) || (s1_op == avrx_pkg::OP_SBCI);
  assign is_sub  = use_imm || (s1_op == avrx_pkg::OP_SUB);
  assign cin     = ((s1_op == avrx_pkg::OP_ADC) || (s1_op == avrx_pkg::OP_SBCI))
                   && flags[avrx_pkg::FLAG_C];
  assign b       = use_imm ? kimm : b_reg;
  assign sum9    = {1'b0, a} + {1'b0, b} + {8'b0, cin};
  assign dif9    = {1'b0, a} - {1'b0, b} - {8'b0, cin};
  assign res9    = is_sub ? dif9 : sum9;
  assign r       = res9[7:0];
  assign hc      = a[4] ^ b[4] ^ res9[4];
  assign vf      = is_sub ? ((a[7] ^ b[7]) & (a[7] ^ r[7]))
                          : ((a[7] ^ r[7]) & (b[7] ^ r[7]));
  // SBCI only keeps Z set across a zero result; it never sets it.
  assign zf      = (r == 8'h00) &&
                   ((s1_op != avrx_pkg::OP_SBCI) || flags[avrx_pkg::FLAG_Z]);

  assign k16     = {10'b0, s1_instr[7:6], s1_instr[3:0]};
  assign res16   = rdata_a - k16;
  assign v16     = rdata_a[15] & ~res16[15];

  assign io_addr = {s1_instr[10:9], s1_instr[3:0]};
  assign rj_off  = {{4{s1_instr[11]}}, s1_instr[11:0]};
  assign br_off  = {{9{s1_instr[9]}}, s1_instr[9:3]};
  assign pc_inc  = pc + avrx_pkg::PC_BITS'(1);

  always_comb begin
    flags_next = flags;
    pc_next    = pc_inc;
    port_next  = port;
    wrote      = 1'b0;
    widx       = '0;
    wval       = '0;
    wr         = '0;
    unique case (s1_op)
      avrx_pkg::OP_ADD, avrx_pkg::OP_ADC, avrx_pkg::OP_SUB,
      avrx_pkg::OP_SUBI, avrx_pkg::OP_SBCI: begin
        flags_next[avrx_pkg::FLAG_C] = res9[8];
        flags_next[avrx_pkg::FLAG_Z] = zf;
        flags_next[avrx_pkg::FLAG_N] = r[7];
        flags_next[avrx_pkg::FLAG_V] = vf;
        flags_next[avrx_pkg::FLAG_S] = r[7] ^ vf;
        flags_next[avrx_pkg::FLAG_H] = hc;
        wrote = 1'b1;
        widx  = use_imm ? rdh : rd5;
        wval  = r;
      end
      avrx_pkg::OP_LDI: begin
        wrote = 1'b1;
        widx  = rdh;
        wval  = kimm;
      end
      avrx_pkg::OP_SBIW: begin
        flags_next[avrx_pkg::FLAG_C] = res16[15] & ~rdata_a[15];
        flags_next[avrx_pkg::FLAG_Z] = (res16 == 16'h0000);
        flags_next[avrx_pkg::FLAG_N] = res16[15];
        flags_next[avrx_pkg::FLAG_V] = v16;
        flags_next[avrx_pkg::FLAG_S] = res16[15] ^ v16;
        wrote = 1'b1;
        widx  = {2'b11, s1_instr[5:4], 1'b0};
        wval  = res16[7:0];
      end
      avrx_pkg::OP_CLC: flags_next[avrx_pkg::FLAG_C] = 1'b0;
      avrx_pkg::OP_SEC: flags_next[avrx_pkg::FLAG_C] = 1'b1;
      avrx_pkg::OP_OUT: begin
        if (io_addr == avrx_pkg::PORT_ADDR) port_next = a[5:0];
      end
      avrx_pkg::OP_RJMP: pc_next = pc_inc + rj_off[avrx_pkg::PC_BITS-1:0];
      avrx_pkg::OP_BRNE: begin
        if (!flags[avrx_pkg::FLAG_Z]) pc_next = pc_inc + br_off[avrx_pkg::PC_BITS-1:0];
      end
      default: begin
      end
    endcase

    // A word op writes the whole pair; byte ops write one half of the row.
    wr.en   = wrote && s1_go;
    wr.row  = widx[avrx_pkg::REG_BITS-1:1];
    if (s1_op == avrx_pkg::OP_SBIW) begin
      wr.be   = 2'b11;
      wr.data = res16;
    end else begin
      wr.be   = widx[0] ? 2'b10 : 2'b01;
      wr.data = {wval, wval};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      pc    <= '0;
      port  <= '0;
    end else if (s1_go) begin
      flags <= flags_next;
      pc    <= pc_next;
      port  <= port_next;
    end
  end

  // Result register: the receiver may stall it while execute fills behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      next_pc       <= 12'(pc_next);
      status_flags  <= flags_next;
      pin_levels    <= port_next;
      reg_written   <= wrote;
      written_index <= widx;
      written_value <= wval;
    end
  end

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted item did not reach the execute stage");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_instr))
    else $error("stalled execute stage lost its item");

  a_exec_loads_result: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid)
    else $error("executed item produced no result");

  a_write_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> s1_go && wrote)
    else $error("register write outside of execution");

  a_pair_write_full: assert property (@(posedge clk) disable iff (rst)
    wr.en && (s1_op == avrx_pkg::OP_SBIW) |-> wr.be == 2'b11)
    else $error("word write did not update both registers of the pair");

endmodule

/* verif/avrx_tb_pkg.sv */
`timescale 1ns / 1ps
// Opcode prefixes and fixed instruction words shared by the executor checker and the
// testbench top. No dependencies. Compile it before the other verif files.
package avrx_tb_pkg;

  localparam logic [5:0]  PFX_ADD   = 6'b000011;
  localparam logic [5:0]  PFX_ADC   = 6'b000111;
  localparam logic [5:0]  PFX_SUB   = 6'b000110;
  localparam logic [3:0]  NIB_SUBI  = 4'h5;
  localparam logic [3:0]  NIB_SBCI  = 4'h4;
  localparam logic [3:0]  NIB_LDI   = 4'hE;
  localparam logic [3:0]  NIB_RJMP  = 4'hC;
  localparam logic [7:0]  PFX_SBIW  = 8'h97;
  localparam logic [4:0]  PFX_OUT   = 5'b10111;
  localparam logic [5:0]  PFX_BRNE  = 6'b111101;
  localparam logic [2:0]  BRNE_TAIL = 3'b001;
  localparam logic [15:0] WORD_CLC  = 16'h9488;
  localparam logic [15:0] WORD_SEC  = 16'h9408;
  localparam logic [15:0] WORD_NOP  = 16'h0000;

endpackage

/* verif/avrx_exec_checker.sv */
`timescale 1ns / 1ps
// Checker for the instruction executor: predicts each result from accepted items and
// compares the results in order. Depends on avrx_pkg and avrx_tb_pkg.
module avrx_exec_checker
  import avrx_pkg::*;
  import avrx_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] instruction,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [11:0] next_pc,
  input  logic [7:0]  status_flags,
  input  logic [5:0]  pin_levels,
  input  logic        reg_written,
  input  logic [4:0]  written_index,
  input  logic [7:0]  written_value,
  input  logic        out_valid,
  input  logic        out_ready,
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic [11:0] npc;
    logic [7:0]  sreg;
    logic [5:0]  pins;
    logic        wr;
    logic [4:0]  widx;
    logic [7:0]  wval;
  } exec_result_t;

  logic [7:0]         regs [REG_COUNT];
  logic [7:0]         sreg;
  logic [PC_BITS-1:0] pc;
  logic [5:0]         pins;

  exec_result_t predicted_outcomes[$];
  exec_result_t seen;
  exec_result_t want;
  int           result_number;

  initial begin
    mismatch_count = 0;
    outstanding    = 0;
    result_number  = 0;
  end

  function automatic op_t classify(input logic [15:0] w);
    op_t op;
    op = OP_NOP;
    if (w[15:10] == PFX_ADD) op = OP_ADD;
    else if (w[15:10] == PFX_ADC) op = OP_ADC;
    else if (w[15:10] == PFX_SUB) op = OP_SUB;
    else if (w[15:12] == NIB_SUBI) op = OP_SUBI;
    else if (w[15:12] == NIB_SBCI) op = OP_SBCI;
    else if (w[15:8] == PFX_SBIW) op = OP_SBIW;
    else if (w[15:12] == NIB_LDI) op = OP_LDI;
    else if (w == WORD_CLC) op = OP_CLC;
    else if (w == WORD_SEC) op = OP_SEC;
    else if (w[15:11] == PFX_OUT) op = OP_OUT;
    else if (w[15:12] == NIB_RJMP) op = OP_RJMP;
    else if (w[15:10] == PFX_BRNE && w[2:0] == BRNE_TAIL) op = OP_BRNE;
    return op;
  endfunction

  function automatic void set_arith_flags(input logic [7:0] r, input logic c, input logic v,
                                          input logic h, input logic keep_z);
    logic z;
    z = (r == 8'h00);
    if (keep_z) z = z & sreg[FLAG_Z];
    sreg[FLAG_C] = c;
    sreg[FLAG_Z] = z;
    sreg[FLAG_N] = r[7];
    sreg[FLAG_V] = v;
    sreg[FLAG_S] = r[7] ^ v;
    sreg[FLAG_H] = h;
  endfunction

  function automatic logic [7:0] add8(input logic [7:0] a, input logic [7:0] b,
                                      input logic cin);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {8'b0, cin};
    set_arith_flags(sum[7:0], sum[8], (a[7] ^ sum[7]) & (b[7] ^ sum[7]),
                    a[4] ^ b[4] ^ sum[4], 1'b0);
    return sum[7:0];
  endfunction

  function automatic logic [7:0] sub8(input logic [7:0] a, input logic [7:0] b,
                                      input logic cin, input logic keep_z);
    logic [8:0] diff;
    diff = {1'b0, a} - {1'b0, b} - {8'b0, cin};
    set_arith_flags(diff[7:0], diff[8], (a[7] ^ b[7]) & (a[7] ^ diff[7]),
                    a[4] ^ b[4] ^ diff[4], keep_z);
    return diff[7:0];
  endfunction

  // Executes one word against the predicted architectural state.
  function automatic exec_result_t execute_instruction(input logic [15:0] w);
    exec_result_t       res;
    op_t                op;
    logic [4:0]         rd;
    logic [4:0]         rr;
    logic [4:0]         rh;
    logic [7:0]         k;
    logic [4:0]         lo;
    logic [15:0]        old;
    logic [15:0]        wide;
    logic [5:0]         addr;
    logic [15:0]        offset;
    logic [PC_BITS-1:0] nxt;
    res  = '0;
    op   = classify(w);
    rd   = w[8:4];
    rr   = {w[9], w[3:0]};
    rh   = {1'b1, w[7:4]};
    k    = {w[11:8], w[3:0]};
    nxt  = pc + 1'b1;
    case (op)
      OP_ADD: begin
        res.wval = add8(regs[rd], regs[rr], 1'b0);
        res.widx = rd;
        res.wr   = 1'b1;
      end
      OP_ADC: begin
        res.wval = add8(regs[rd], regs[rr], sreg[FLAG_C]);
        res.widx = rd;
        res.wr   = 1'b1;
      end
      OP_SUB: begin
        res.wval = sub8(regs[rd], regs[rr], 1'b0, 1'b0);
        res.widx = rd;
        res.wr   = 1'b1;
      end
      OP_SUBI: begin
        res.wval = sub8(regs[rh], k, 1'b0, 1'b0);
        res.widx = rh;
        res.wr   = 1'b1;
      end
      OP_SBCI: begin
        res.wval = sub8(regs[rh], k, sreg[FLAG_C], 1'b1);
        res.widx = rh;
        res.wr   = 1'b1;
      end
      OP_SBIW: begin
        // Word subtract on a pair; H is not touched.
        lo   = 5'd24 + {2'b00, w[5:4], 1'b0};
        old  = {regs[lo + 5'd1], regs[lo]};
        wide = old - {10'b0, w[7:6], w[3:0]};
        sreg[FLAG_C] = wide[15] & ~old[15];
        sreg[FLAG_Z] = (wide == 16'h0000);
        sreg[FLAG_N] = wide[15];
        sreg[FLAG_V] = old[15] & ~wide[15];
        sreg[FLAG_S] = wide[15] ^ (old[15] & ~wide[15]);
        regs[lo]        = wide[7:0];
        regs[lo + 5'd1] = wide[15:8];
        res.wval = wide[7:0];
        res.widx = lo;
        res.wr   = 1'b1;
      end
      OP_LDI: begin
        res.wval = k;
        res.widx = rh;
        res.wr   = 1'b1;
      end
      OP_CLC: sreg[FLAG_C] = 1'b0;
      OP_SEC: sreg[FLAG_C] = 1'b1;
      OP_OUT: begin
        addr = {w[10:9], w[3:0]};
        if (addr == PORT_ADDR) pins = regs[rd][5:0];
      end
      OP_RJMP: begin
        offset = {{4{w[11]}}, w[11:0]};
        nxt    = pc + 1'b1 + offset[PC_BITS-1:0];
      end
      OP_BRNE: begin
        if (!sreg[FLAG_Z]) begin
          offset = {{9{w[9]}}, w[9:3]};
          nxt    = pc + 1'b1 + offset[PC_BITS-1:0];
        end
      end
      default: ;
    endcase
    if (res.wr && op != OP_SBIW) regs[res.widx] = res.wval;
    pc       = nxt;
    res.npc  = 12'(pc);
    res.sreg = sreg;
    res.pins = pins;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) regs[i] = 8'h00;
      sreg = 8'h00;
      pc   = '0;
      pins = 6'h00;
      predicted_outcomes.delete();
    end else begin
      // Results are retired before the item of this edge is predicted.
      if (out_valid && out_ready) begin
        seen = {next_pc, status_flags, pin_levels, reg_written, written_index, written_value};
        result_number++;
        if (predicted_outcomes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with no item outstanding", result_number);
        end else begin
          want = predicted_outcomes.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d: expected pc=%h flags=%h pins=%h wr=%b idx=%0d val=%h,",
                       result_number, want.npc, want.sreg, want.pins, want.wr, want.widx,
                       want.wval,
                       " got pc=%h flags=%h pins=%h wr=%b idx=%0d val=%h",
                       seen.npc, seen.sreg, seen.pins, seen.wr, seen.widx, seen.wval);
          end
        end
      end
      if (in_valid && in_ready) predicted_outcomes.push_back(execute_instruction(instruction));
    end
    outstanding = predicted_outcomes.size();
  end

endmodule

/* verif/avr_subset_instruction_execute_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the instruction executor: clock, reset, stimulus and verdict.
// Depends on avrx_pkg, avrx_tb_pkg, avrx_exec_checker and the executor RTL.
module avr_subset_instruction_execute_top_tb;
  import avrx_pkg::*;
  import avrx_tb_pkg::*;

  // The slowest correct run is roughly 1650 items plus the long receiver hold-off,
  // so this limit is many times over what is needed.
  localparam int CYCLE_LIMIT      = 200000;
  localparam int HOLD_CYCLES      = 400;
  localparam int HOLD_AFTER_ITEMS = 300;
  localparam int ITEMS_PER_PHASE  = 534;
  localparam int SETTLE_CYCLES    = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] instruction = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] next_pc;
  logic [7:0]  status_flags;
  logic [5:0]  pin_levels;
  logic        reg_written;
  logic [4:0]  written_index;
  logic [7:0]  written_value;
  logic        out_valid;
  logic        out_ready = 1'b0;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_active = 1'b0;
  int   accepted_items = 0;
  int   cycle_count = 0;
  int   mismatch_count;
  int   outstanding;

  always #6 clk = ~clk;

  avr_subset_instruction_execute_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .instruction   (instruction),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .next_pc       (next_pc),
    .status_flags  (status_flags),
    .pin_levels    (pin_levels),
    .reg_written   (reg_written),
    .written_index (written_index),
    .written_value (written_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  avrx_exec_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .instruction    (instruction),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .next_pc        (next_pc),
    .status_flags   (status_flags),
    .pin_levels     (pin_levels),
    .reg_written    (reg_written),
    .written_index  (written_index),
    .written_value  (written_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  // The receiver takes a fresh random decision every cycle, unless the long hold-off
  // is running, in which case it refuses everything.
  always @(posedge clk) begin
    if (rst || hold_active) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) accepted_items <= accepted_items + 1;
  end

  // Once the random part is well under way, the receiver stops for a long stretch
  // while the sender keeps offering items. The result register and the execute
  // stage fill up and in_ready has to drop.
  initial begin
    wait (accepted_items >= HOLD_AFTER_ITEMS);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Instruction encoders. Register indexes are full 5-bit numbers; the immediate
  // forms only carry the low four bits, since they address r16 to r31.
  function automatic logic [15:0] enc_pair(input logic [5:0] pfx, input logic [4:0] d,
                                           input logic [4:0] r);
    return {pfx, r[4], d, r[3:0]};
  endfunction

  function automatic logic [15:0] enc_imm(input logic [3:0] nib, input logic [4:0] d,
                                          input logic [7:0] k);
    return {nib, k[7:4], d[3:0], k[3:0]};
  endfunction

  function automatic logic [15:0] enc_sbiw(input logic [1:0] pair, input logic [5:0] k);
    return {PFX_SBIW, k[5:4], pair, k[3:0]};
  endfunction

  function automatic logic [15:0] enc_out(input logic [5:0] a, input logic [4:0] r);
    return {PFX_OUT, a[5:4], r, a[3:0]};
  endfunction

  function automatic logic [15:0] enc_rjmp(input logic [11:0] k);
    return {NIB_RJMP, k};
  endfunction

  function automatic logic [15:0] enc_brne(input logic [6:0] k);
    return {PFX_BRNE, k, BRNE_TAIL};
  endfunction

  // A well-formed instruction of the given kind with random operands. Half of the
  // OUT instructions hit the port so that the pins move often.
  function automatic logic [15:0] build_word(input op_t op);
    logic [15:0] w;
    case (op)
      OP_ADD:  w = enc_pair(PFX_ADD, 5'($urandom), 5'($urandom));
      OP_ADC:  w = enc_pair(PFX_ADC, 5'($urandom), 5'($urandom));
      OP_SUB:  w = enc_pair(PFX_SUB, 5'($urandom), 5'($urandom));
      OP_SUBI: w = enc_imm(NIB_SUBI, 5'($urandom), 8'($urandom));
      OP_SBCI: w = enc_imm(NIB_SBCI, 5'($urandom), 8'($urandom));
      OP_SBIW: w = enc_sbiw(2'($urandom), 6'($urandom));
      OP_LDI:  w = enc_imm(NIB_LDI, 5'($urandom), 8'($urandom));
      OP_CLC:  w = WORD_CLC;
      OP_SEC:  w = WORD_SEC;
      OP_OUT:  w = enc_out($urandom_range(1) ? PORT_ADDR : 6'($urandom), 5'($urandom));
      OP_RJMP: w = enc_rjmp(12'($urandom));
      OP_BRNE: w = enc_brne(7'($urandom));
      default: w = WORD_NOP;
    endcase
    return w;
  endfunction

  // Mostly well-formed instructions; one in ten is a raw word, which also takes
  // every bit of the instruction through both values.
  function automatic logic [15:0] random_word();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return build_word(op_t'($urandom_range(int'(OP_BRNE))));
  endfunction

  // Offers one item. Valid only drops when a gap is drawn, so back-to-back items
  // keep it high without a second assignment in the same step.
  task automatic send_item(input logic [15:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    instruction <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // The sender stops until every predicted result has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Directed part: register extremes, every operation, the SBCI zero rule with Z both
  // set and clear, the port and a foreign I/O address, jumps both ways, a taken and
  // a falling-through branch, and a word that decodes to nothing.
  task automatic run_directed();
    logic [15:0] words[$];
    words = '{
      WORD_NOP,
      enc_imm(NIB_LDI, 5'd16, 8'hFF),
      enc_imm(NIB_LDI, 5'd31, 8'h01),
      enc_pair(PFX_ADD, 5'd16, 5'd31),   // wraps to zero with carry and half carry
      enc_pair(PFX_ADC, 5'd31, 5'd31),   // pulls the carry in
      enc_pair(PFX_SUB, 5'd0, 5'd31),    // borrow from r0
      enc_imm(NIB_SUBI, 5'd16, 8'h80),   // signed overflow
      enc_imm(NIB_LDI, 5'd20, 8'h05),
      enc_imm(NIB_SUBI, 5'd20, 8'h05),   // zero result sets Z
      enc_imm(NIB_SBCI, 5'd20, 8'h00),   // zero again, Z was set and stays set
      enc_imm(NIB_LDI, 5'd22, 8'h02),
      enc_imm(NIB_SUBI, 5'd22, 8'h01),   // nonzero result clears Z
      WORD_SEC,
      enc_imm(NIB_SBCI, 5'd22, 8'h00),   // zero with Z clear, Z must stay clear
      WORD_CLC,
      enc_sbiw(2'd0, 6'h3F),             // r25:r24 wraps below zero
      enc_imm(NIB_LDI, 5'd17, 8'hEA),
      enc_out(PORT_ADDR, 5'd17),
      enc_out(6'h3F, 5'd0),              // other I/O address, pins unchanged
      enc_rjmp(12'hFFF),                 // jump to itself
      enc_rjmp(12'h7FF),                 // farthest forward jump
      enc_brne(7'h40),                   // Z clear: farthest backward branch
      enc_imm(NIB_SUBI, 5'd20, 8'h00),   // r20 is zero, sets Z
      enc_brne(7'h3F),                   // Z set: falls through
      16'hFFFF
    };
    foreach (words[i]) send_item(words[i]);
  endtask

  initial begin
    recv_idle_pct <= 74;
    send_idle_pct = 23;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    drain();

    // First phase: sparse sender, slow receiver. The long hold-off falls in here.
    repeat (ITEMS_PER_PHASE) send_item(random_word());
    drain();

    // Second phase: the roles swap.
    send_idle_pct = 74;
    recv_idle_pct <= 23;
    repeat (ITEMS_PER_PHASE) send_item(random_word());
    drain();

    // Third phase: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    repeat (ITEMS_PER_PHASE) send_item(random_word());
    drain();

    // Give a stray extra result time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
